// ----- rtl/core/ultrasonic_echo_ranger_core_assert.svh -----
// Assertion macros used by the ranger core.
`ifndef ULTRASONIC_ECHO_RANGER_CORE_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UER_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UER_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/uer_pkg.sv -----
`default_nettype none

package uer_pkg;

    localparam int TRIG_LOW_TICKS  = 2;
    localparam int TRIG_HIGH_TICKS = 10;

    localparam int TIMEOUT_W     = 10;
    localparam int CNT_W         = 20;
    localparam int DIST_W        = 15;
    localparam int MS_TICKS      = 1000;
    localparam int TIMEOUT_RESET = 100;

    // floor(p * 17 / 1000) == (p * DIST_RECIP) >> DIST_SHIFT for every p below 2**20.
    localparam int DIST_SHIFT = 35;
    localparam int RECIP_W    = 30;
    localparam logic [RECIP_W-1:0] DIST_RECIP = 30'd584115563;

    localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'((TIMEOUT_RESET + 1) * MS_TICKS);

    typedef struct packed {
        logic             trigger_out;
        logic             busy_res;
        logic             done_res;
        logic             timed_out;
        logic [CNT_W-1:0] pulse_us;
    } step_res_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance_cm;
        logic [CNT_W-1:0]  pulse_us;
        logic              timed_out;
        logic              done_res;
        logic              busy_res;
        logic              trigger_out;
    } out_res_t;

endpackage

`default_nettype wire

// ----- rtl/core/uer_step.sv -----
`default_nettype none

module uer_step
    import uer_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             func,
    input  wire logic             echo_level,
    input  wire logic [CNT_W-1:0] limit,
    output step_res_t             res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TRIG_LOW,
        PH_TRIG_HIGH,
        PH_WAIT_END,
        PH_WAIT_RISE,
        PH_MEASURE
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    step_res_t        res_reg, res_next;

    always_comb begin
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] inc;
        phase_t           ph;
        logic             done;

        ph   = phase_reg;
        cnt  = count_reg;
        done = 1'b0;
        res_next = '0;

        if (ph == PH_IDLE && func) begin
            ph  = PH_TRIG_LOW;
            cnt = '0;
        end
        inc = cnt + CNT_W'(1);

        case (ph)
            PH_TRIG_LOW: begin
                cnt = inc;
                if (inc >= CNT_W'(TRIG_LOW_TICKS)) begin
                    ph  = PH_TRIG_HIGH;
                    cnt = '0;
                end
            end
            PH_TRIG_HIGH: begin
                res_next.trigger_out = 1'b1;
                cnt = inc;
                if (inc >= CNT_W'(TRIG_HIGH_TICKS)) begin
                    ph  = PH_WAIT_END;
                    cnt = '0;
                end
            end
            PH_WAIT_END: begin
                if (echo_level) begin
                    cnt = inc;
                    if (inc >= limit) begin
                        done = 1'b1;
                        res_next.timed_out = 1'b1;
                    end
                end else begin
                    ph  = PH_WAIT_RISE;
                    cnt = '0;
                end
            end
            PH_WAIT_RISE: begin
                if (!echo_level) begin
                    cnt = inc;
                    if (inc >= limit) begin
                        done = 1'b1;
                        res_next.timed_out = 1'b1;
                    end
                end else begin
                    ph  = PH_MEASURE;
                    cnt = CNT_W'(1);
                    if (CNT_W'(1) >= limit) begin
                        done = 1'b1;
                        res_next.timed_out = 1'b1;
                    end
                end
            end
            PH_MEASURE: begin
                if (echo_level) begin
                    cnt = inc;
                    if (inc >= limit) begin
                        done = 1'b1;
                        res_next.timed_out = 1'b1;
                    end
                end else begin
                    done = 1'b1;
                    res_next.pulse_us = cnt;
                end
            end
            default: begin
                ph = PH_IDLE;
            end
        endcase

        if (done) begin
            ph  = PH_IDLE;
            cnt = '0;
        end

        res_next.done_res = done;
        res_next.busy_res = (ph != PH_IDLE);
        phase_next = ph;
        count_next = cnt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
        end else if (en) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ----- rtl/core/uer_scale.sv -----
`default_nettype none

module uer_scale
    import uer_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      en,
    input  wire step_res_t step,
    output out_res_t       res
);

    out_res_t                   res_reg, res_next;
    logic [CNT_W+RECIP_W-1:0]   prod;

    assign prod = (CNT_W+RECIP_W)'(step.pulse_us) * (CNT_W+RECIP_W)'(DIST_RECIP);

    always_comb begin
        res_next.trigger_out = step.trigger_out;
        res_next.busy_res    = step.busy_res;
        res_next.done_res    = step.done_res;
        res_next.timed_out   = step.timed_out;
        res_next.pulse_us    = step.pulse_us;
        res_next.distance_cm = prod[DIST_SHIFT +: DIST_W];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ultrasonic_echo_ranger_core.sv -----
// Channel   Ports                     Content
// input     s_tvalid/s_tready         s_tuser = func, s_tdata[0] = echo_level
// result    m_tvalid/m_tready         m_tdata = trigger/busy/done/timeout/pulse/distance
// config    cfg_we/cfg_wdata          timeout_ms
//
// One item is accepted per cycle while s_tready is high; each item passes the input, step
// and result registers in turn. The per-tick phase update is a single registered step.
// Reset sets the timeout to 100 ms and puts the sequencer in idle.
// Each stage holds its item while the next one is full, so a stalled result does not
// stop items from entering until all three stages are occupied.
`default_nettype none

module ultrasonic_echo_ranger_core
    import uer_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [TIMEOUT_W-1:0] cfg_wdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [0] echo_level, [7:1] zero
    input  wire logic                 s_tuser,   // [0] func
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [39:0]               m_tdata    // [0] trigger_out, [1] busy_res,
                                                 // [2] done_res, [3] timed_out,
                                                 // [23:4] pulse_us, [38:24] distance_cm
);

    `include "ultrasonic_echo_ranger_core_assert.svh"

    logic [CNT_W-1:0] limit_reg;
    logic             in_vld_reg, func_reg, echo_reg;
    logic             step_vld_reg, out_vld_reg;
    logic             ready_out, ready_step;
    step_res_t        step_res;
    out_res_t         out_res;

    assign ready_out  = !out_vld_reg || m_tready;
    assign ready_step = !step_vld_reg || ready_out;
    assign s_tready   = !in_vld_reg || ready_step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_we) begin
            limit_reg <= CNT_W'(({1'b0, cfg_wdata} + (TIMEOUT_W+1)'(1)))
                         * CNT_W'(MS_TICKS);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg   <= 1'b0;
            step_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            if (ready_step) begin
                step_vld_reg <= in_vld_reg;
            end
            if (ready_out) begin
                out_vld_reg <= step_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            func_reg <= s_tuser;
            echo_reg <= s_tdata[0];
        end
    end

    uer_step u_step (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (in_vld_reg && ready_step),
        .func       (func_reg),
        .echo_level (echo_reg),
        .limit      (limit_reg),
        .res        (step_res)
    );

    uer_scale u_scale (
        .aclk (aclk),
        .en   (step_vld_reg && ready_out),
        .step (step_res),
        .res  (out_res)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0, out_res};

    `UER_ASSERT_SAME(a_timeout_with_done, aclk, aresetn,
        m_tvalid && m_tdata[3], m_tdata[2], "timeout reported without done")
    `UER_ASSERT_SAME(a_done_not_busy, aclk, aresetn,
        m_tvalid && m_tdata[2], !m_tdata[1], "busy still set on finishing item")
    `UER_ASSERT_SAME(a_no_pulse_idle, aclk, aresetn,
        m_tvalid && !m_tdata[2], m_tdata[38:4] == 35'd0, "pulse reported without done")
    `UER_ASSERT_NEXT(a_step_drains, aclk, aresetn,
        step_vld_reg && ready_out, m_tvalid, "step item lost before result register")

endmodule

`default_nettype wire

// ----- sim/tb_ultrasonic_echo_ranger_core.sv -----
`timescale 1ns / 100ps

module tb_ultrasonic_echo_ranger_core;
    import uer_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 80;
    localparam int BUSY_START_PCT = 20;
    localparam int DIST_NUM = 17;
    localparam int DIST_DEN = 1000;
    localparam longint WATCHDOG_NS = 24_000_000;

    typedef enum logic [2:0] {
        RG_IDLE,
        RG_TRIG_LOW,
        RG_TRIG_HIGH,
        RG_WAIT_END,
        RG_WAIT_RISE,
        RG_MEASURE
    } ranger_phase_t;

    class ranger_scoreboard_t;
        logic [TIMEOUT_W-1:0] timeout_ms;
        ranger_phase_t phase;
        logic [CNT_W-1:0] count;
        out_res_t expected_q[$];
        int errors;

        function new();
            timeout_ms = TIMEOUT_W'(TIMEOUT_RESET);
            phase = RG_IDLE;
            count = '0;
            errors = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_input(logic func, logic echo);
            out_res_t r;
            int unsigned lim;
            bit check_limit;
            r = '0;
            check_limit = 1'b0;
            lim = (int'(timeout_ms) + 1) * MS_TICKS;
            if (phase == RG_IDLE && func) begin
                phase = RG_TRIG_LOW;
                count = '0;
            end
            case (phase)
                RG_TRIG_LOW: begin
                    count++;
                    if (count >= TRIG_LOW_TICKS) begin
                        phase = RG_TRIG_HIGH;
                        count = '0;
                    end
                end
                RG_TRIG_HIGH: begin
                    r.trigger_out = 1'b1;
                    count++;
                    if (count >= TRIG_HIGH_TICKS) begin
                        phase = RG_WAIT_END;
                        count = '0;
                    end
                end
                RG_WAIT_END: begin
                    if (echo) begin
                        count++;
                        check_limit = 1'b1;
                    end else begin
                        phase = RG_WAIT_RISE;
                        count = '0;
                    end
                end
                RG_WAIT_RISE: begin
                    if (!echo) begin
                        count++;
                    end else begin
                        phase = RG_MEASURE;
                        count = CNT_W'(1);
                    end
                    check_limit = 1'b1;
                end
                RG_MEASURE: begin
                    if (echo) begin
                        count++;
                        check_limit = 1'b1;
                    end else begin
                        r.done_res = 1'b1;
                        r.pulse_us = count;
                        r.distance_cm = DIST_W'((64'(count) * DIST_NUM) / DIST_DEN);
                    end
                end
                default: begin
                    phase = RG_IDLE;
                end
            endcase
            if (check_limit && count >= lim) begin
                r.done_res = 1'b1;
                r.timed_out = 1'b1;
            end
            if (r.done_res) begin
                phase = RG_IDLE;
                count = '0;
            end
            r.busy_res = (phase != RG_IDLE);
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [39:0] data);
            out_res_t got;
            out_res_t want;
            got = out_res_t'(data[38:0]);
            if (expected_q.size() == 0) begin
                $error("result with no item waiting: %h", data);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("trigger_out", want.trigger_out, got.trigger_out);
            compare_field("busy_res", want.busy_res, got.busy_res);
            compare_field("done_res", want.done_res, got.done_res);
            compare_field("timed_out", want.timed_out, got.timed_out);
            compare_field("pulse_us", want.pulse_us, got.pulse_us);
            compare_field("distance_cm", want.distance_cm, got.distance_cm);
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [TIMEOUT_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [39:0] m_tdata;

    ranger_scoreboard_t sb = new();
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int items_sent = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;

    ultrasonic_echo_ranger_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_served != hold_requests) begin
            m_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            sb.note_input(s_tuser, s_tdata[0]);
        end
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata);
        end
    end

    task automatic send_item(input logic func, input logic echo);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {7'd0, echo};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_ticks(input int n, input logic echo, input int start_pct);
        for (int i = 0; i < n; i++) begin
            send_item($urandom_range(99) < start_pct, echo);
        end
    endtask

    // One start item, the rest of the trigger ticks, then the echo as seen by the sensor pin.
    task automatic send_measurement(input int high_before, input int low_wait, input int pulse,
                                    input int start_pct);
        send_item(1'b1, 1'($urandom_range(1)));
        for (int i = 0; i < TRIG_LOW_TICKS + TRIG_HIGH_TICKS - 1; i++) begin
            send_item($urandom_range(99) < start_pct, 1'($urandom_range(1)));
        end
        send_ticks(high_before, 1'b1, start_pct);
        send_ticks(low_wait + 1, 1'b0, start_pct);
        send_ticks(pulse, 1'b1, start_pct);
        send_ticks(1, 1'b0, start_pct);
    endtask

    // One echo phase runs up to its limit or stops one tick short of it.
    task automatic send_near_limit();
        int lim;
        int near;
        lim = (int'(sb.timeout_ms) + 1) * MS_TICKS;
        near = $urandom_range(lim, lim - 1);
        case ($urandom_range(2))
            0: send_measurement(near, 0, 1, 0);
            1: send_measurement(0, near, 1, 0);
            default: send_measurement(0, 0, near, 0);
        endcase
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_timeout(input int value);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= TIMEOUT_W'(value);
        sb.timeout_ms = TIMEOUT_W'(value);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase();
        int start;
        int high_before;
        int low_wait;
        int pulse;
        int sel;
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS) begin
            high_before = $urandom_range(6);
            low_wait = $urandom_range(12);
            pulse = $urandom_range(40, 1);
            sel = $urandom_range(99);
            if (sel >= 90) begin
                pulse = $urandom_range(200, 41);
            end
            send_measurement(high_before, low_wait, pulse, BUSY_START_PCT);
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(30, 1)) begin
                    send_item($urandom_range(9) == 0, 1'($urandom_range(1)));
                end
            end else begin
                send_ticks($urandom_range(4), 1'($urandom_range(1)), 0);
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(1'b0, 1'b0);
        send_item(1'b0, 1'b1);
        send_item(1'b1, 1'b1);
        for (int i = 0; i < TRIG_LOW_TICKS + TRIG_HIGH_TICKS - 1; i++) begin
            send_item(i % 3 == 0, 1'(i % 2));
        end
        send_ticks(2, 1'b1, 0);
        send_ticks(2, 1'b0, 0);
        send_ticks(3, 1'b1, 0);
        send_item(1'b0, 1'b0);
        random_phase();

        set_timeout(0);
        tx_idle_pct = 53;
        rx_stall_pct = 0;
        send_near_limit();
        random_phase();

        set_timeout(1000);
        tx_idle_pct = 0;
        rx_stall_pct = 53;
        random_phase();

        set_timeout($urandom_range(999, 2));
        tx_idle_pct = 30;
        rx_stall_pct = 30;
        random_phase();

        set_timeout(1);
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        hold_requests++;
        random_phase();

        drain();
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #(WATCHDOG_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/uer_pkg.sv
rtl/core/uer_step.sv
rtl/core/uer_scale.sv
rtl/core/ultrasonic_echo_ranger_core.sv
sim/tb_ultrasonic_echo_ranger_core.sv
